>>> sv/pip_pkg.sv
// package: shared types, widths and operation codes for the point in polygon test
`default_nettype none
package pip_pkg;

  localparam int DEFAULT_MAX_VERTICES = 16;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RES   = 4'b1000
  } state_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] yi;
    logic signed [COORD_W-1:0] xj;
    logic signed [COORD_W-1:0] yj;
  } edge_t;

endpackage
`default_nettype wire

>>> sv/pip_cell.sv
// module: one vertex cell of the rotating vertex ring
`default_nettype none
module pip_cell (
  input  wire logic                               clk,
  input  wire logic                               shift,
  input  wire logic                               load,
  input  wire logic signed [pip_pkg::COORD_W-1:0] load_x,
  input  wire logic signed [pip_pkg::COORD_W-1:0] load_y,
  input  wire logic signed [pip_pkg::COORD_W-1:0] nbr_x,
  input  wire logic signed [pip_pkg::COORD_W-1:0] nbr_y,
  output logic signed [pip_pkg::COORD_W-1:0]      x,
  output logic signed [pip_pkg::COORD_W-1:0]      y
);
  import pip_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      x <= nbr_x;
      y <= nbr_y;
    end else if (load) begin
      x <= load_x;
      y <= load_y;
    end
  end

endmodule
`default_nettype wire

>>> sv/pip_edge.sv
// module: pipelined even-odd edge crossing unit with parity accumulator
`default_nettype none
module pip_edge (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               clr,
  input  wire pip_pkg::edge_t                     edge_in,
  input  wire logic signed [pip_pkg::COORD_W-1:0] qx,
  input  wire logic signed [pip_pkg::COORD_W-1:0] qy,
  output logic                                    parity
);
  import pip_pkg::*;

  logic                     straddle;
  logic                     a_vld;
  logic signed [DIFF_W-1:0] a_lhs, a_d, a_rhsa, a_rhsb;
  logic                     b_vld, b_dpos;
  logic signed [PROD_W-1:0] b_p1, b_p2;
  logic                     crossing;

  assign straddle = (edge_in.yi > qy) != (edge_in.yj > qy);

  // stage a: differences
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= edge_in.valid && straddle;
    end
  end

  always_ff @(posedge clk) begin
    a_d    <= DIFF_W'(edge_in.yj) - DIFF_W'(edge_in.yi);
    a_lhs  <= DIFF_W'(qx) - DIFF_W'(edge_in.xi);
    a_rhsa <= DIFF_W'(edge_in.xj) - DIFF_W'(edge_in.xi);
    a_rhsb <= DIFF_W'(qy) - DIFF_W'(edge_in.yi);
  end

  // stage b: products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_p1   <= PROD_W'(a_lhs) * PROD_W'(a_d);
    b_p2   <= PROD_W'(a_rhsa) * PROD_W'(a_rhsb);
    b_dpos <= !a_d[DIFF_W-1] && (|a_d);
  end

  // stage c: compare and toggle
  assign crossing = b_dpos ? (b_p1 < b_p2) : (b_p2 < b_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (clr) begin
      parity <= 1'b0;
    end else if (b_vld && crossing) begin
      parity <= !parity;
    end
  end

endmodule
`default_nettype wire

>>> sv/point_in_polygon_test_top.sv
// top level: polygon vertex ring, bounding box and query sequencer
// clear and append never raise busy
// a query holds busy through one ring rotation
// (MAX_VERTICES + 1 edge issue steps) and a three stage edge pipeline
// the result strobe is in the last busy cycle; no new word is accepted while busy
// synchronous reset empties the polygon, resets the box and overflow flag
`default_nettype none
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = pip_pkg::DEFAULT_MAX_VERTICES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         operation,
  input  wire logic signed [pip_pkg::COORD_W-1:0] coord_x,
  input  wire logic signed [pip_pkg::COORD_W-1:0] coord_y,
  output logic                                    valid,
  output logic                                    inside_res,
  output logic                                    vertex_overflow
);
  import pip_pkg::*;

  localparam int CW = $clog2(MAX_VERTICES + 1);

  state_t                    state, state_next;
  logic [CW-1:0]             count, step;
  logic [1:0]                drain_cnt;
  logic                      overflow_flag;
  logic signed [COORD_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic signed [COORD_W-1:0] qx, qy, first_x, first_y, prev_x, prev_y;
  logic                      in_box;
  logic                      accept, ring_shift, parity;
  edge_t                     edge_in;

  logic signed [COORD_W-1:0] cell_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] cell_y [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]   ld_en;

  assign accept     = start && !busy;
  assign ring_shift = (state == ST_WALK) && (step < CW'(MAX_VERTICES));

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    assign ld_en[k] = accept && (operation == OP_APPEND) && (count == CW'(k));
    pip_cell u_cell (
      .clk    (clk),
      .shift  (ring_shift),
      .load   (ld_en[k]),
      .load_x (coord_x),
      .load_y (coord_y),
      .nbr_x  (cell_x[(k + 1) % MAX_VERTICES]),
      .nbr_y  (cell_y[(k + 1) % MAX_VERTICES]),
      .x      (cell_x[k]),
      .y      (cell_y[k])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (operation == OP_QUERY)) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (step == CW'(MAX_VERTICES)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == 2'd2) state_next = ST_RES;
      end
      ST_RES: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      overflow_flag <= 1'b0;
      box_min_x     <= COORD_MAX;
      box_max_x     <= COORD_MIN;
      box_min_y     <= COORD_MAX;
      box_max_y     <= COORD_MIN;
      step          <= '0;
      drain_cnt     <= '0;
      edge_in       <= '0;
    end else begin
      state         <= state_next;
      if (accept) begin
        if (operation == OP_CLEAR) begin
          count         <= '0;
          overflow_flag <= 1'b0;
          box_min_x     <= COORD_MAX;
          box_max_x     <= COORD_MIN;
          box_min_y     <= COORD_MAX;
          box_max_y     <= COORD_MIN;
        end else if (operation == OP_APPEND) begin
          if (count == CW'(MAX_VERTICES)) begin
            overflow_flag <= 1'b1;
          end else begin
            count <= count + 1'b1;
            if (coord_x < box_min_x) box_min_x <= coord_x;
            if (coord_x > box_max_x) box_max_x <= coord_x;
            if (coord_y < box_min_y) box_min_y <= coord_y;
            if (coord_y > box_max_y) box_max_y <= coord_y;
          end
        end else if (operation == OP_QUERY) begin
          step <= '0;
        end
      end
      if (state == ST_WALK) begin
        step      <= step + 1'b1;
        drain_cnt <= '0;
        priority if (step == '0) begin
          edge_in.valid <= 1'b0;
        end else if (step < count) begin
          edge_in.valid <= 1'b1;
          edge_in.xi    <= cell_x[0];
          edge_in.yi    <= cell_y[0];
          edge_in.xj    <= prev_x;
          edge_in.yj    <= prev_y;
        end else if (step == CW'(MAX_VERTICES)) begin
          // closing edge: first vertex with the last
          edge_in.valid <= (count != '0);
          edge_in.xi    <= first_x;
          edge_in.yi    <= first_y;
          edge_in.xj    <= prev_x;
          edge_in.yj    <= prev_y;
        end else begin
          edge_in.valid <= 1'b0;
        end
      end else begin
        edge_in.valid <= 1'b0;
      end
      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == OP_QUERY)) begin
      qx     <= coord_x;
      qy     <= coord_y;
      in_box <= (coord_x >= box_min_x) && (coord_x <= box_max_x) &&
                (coord_y >= box_min_y) && (coord_y <= box_max_y);
    end
    if ((state == ST_WALK) && (step == '0)) begin
      first_x <= cell_x[0];
      first_y <= cell_y[0];
      prev_x  <= cell_x[0];
      prev_y  <= cell_y[0];
    end else if ((state == ST_WALK) && (step < count)) begin
      prev_x  <= cell_x[0];
      prev_y  <= cell_y[0];
    end
  end

  pip_edge u_edge (
    .clk     (clk),
    .rst     (rst),
    .clr     (accept),
    .edge_in (edge_in),
    .qx      (qx),
    .qy      (qy),
    .parity  (parity)
  );

  assign busy            = (state != ST_IDLE);
  assign valid           = (state == ST_RES);
  assign inside_res      = in_box && parity;
  assign vertex_overflow = overflow_flag;

endmodule
`default_nettype wire

>>> sv/pip_checker.sv
// checker: port level properties of the point in polygon test, bound to the top level
`default_nettype none
module pip_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] operation,
  input wire logic       valid
);
  import pip_pkg::*;

  // a result word only appears while a query is in progress
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result strobe while not busy");

  a_valid_single: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid) else $error("result strobe longer than one cycle");

  a_valid_release: assert property (@(posedge clk) disable iff (rst)
    valid |=> !busy) else $error("busy held after result");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_QUERY)) |=> busy)
    else $error("query did not raise busy");

  a_update_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation != OP_QUERY)) |=> (!busy && !valid))
    else $error("clear or append raised busy or a result");

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (.*);
`default_nettype wire

>>> tb/point_in_polygon_test_top_test.sv
// testbench for the point in polygon test: directed and random words checked against a predictor
`timescale 1ns / 100ps
module point_in_polygon_test_top_test;
  import pip_pkg::*;

  localparam int VERTEX_DEPTH = DEFAULT_MAX_VERTICES;
  localparam int ITEM_TARGET = 700;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = VERTEX_DEPTH + 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic signed [79:0] wide_t;
  typedef struct {
    logic in_poly;
    logic overflow;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] operation = OP_CLEAR;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic busy;
  logic valid;
  logic inside_res;
  logic vertex_overflow;

  logic signed [COORD_W-1:0] poly_x [VERTEX_DEPTH];
  logic signed [COORD_W-1:0] poly_y [VERTEX_DEPTH];
  int poly_count;
  logic signed [COORD_W-1:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  logic dropped_vertex;

  answer_t pending_answers[$];
  int error_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  point_in_polygon_test_top #(.MAX_VERTICES(VERTEX_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .valid(valid),
    .inside_res(inside_res),
    .vertex_overflow(vertex_overflow)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic void empty_polygon();
    poly_count = 0;
    box_lo_x = COORD_MAX;
    box_hi_x = COORD_MIN;
    box_lo_y = COORD_MAX;
    box_hi_y = COORD_MIN;
    dropped_vertex = 1'b0;
  endfunction

  function automatic logic ray_parity(input logic signed [COORD_W-1:0] qx,
                                      input logic signed [COORD_W-1:0] qy);
    logic parity;
    int i, j;
    longint x, y, xi, yi, xj, yj;
    wide_t dy, lx, rx, ry;
    logic crossed;
    parity = 1'b0;
    if (qx < box_lo_x || qx > box_hi_x || qy < box_lo_y || qy > box_hi_y ||
        poly_count == 0)
      return 1'b0;
    x = qx;
    y = qy;
    j = poly_count - 1;
    for (i = 0; i < poly_count; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if ((yi > y) != (yj > y)) begin
        dy = yj - yi;
        lx = x - xi;
        rx = xj - xi;
        ry = y - yi;
        if (dy > 0)
          crossed = (lx * dy) < (rx * ry);
        else
          crossed = (rx * ry) < (lx * dy);
        if (crossed)
          parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  function automatic void apply_word(input logic [1:0] op,
                                     input logic signed [COORD_W-1:0] x,
                                     input logic signed [COORD_W-1:0] y);
    answer_t ans;
    case (op)
      OP_CLEAR: empty_polygon();
      OP_APPEND: begin
        if (poly_count >= VERTEX_DEPTH) begin
          dropped_vertex = 1'b1;
        end else begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
          if (x < box_lo_x) box_lo_x = x;
          if (x > box_hi_x) box_hi_x = x;
          if (y < box_lo_y) box_lo_y = y;
          if (y > box_hi_y) box_hi_y = y;
        end
      end
      OP_QUERY: begin
        ans.in_poly = ray_parity(x, y);
        ans.overflow = dropped_vertex;
        pending_answers.insert(pending_answers.size(), ans);
      end
      default: ;
    endcase
  endfunction

  // called just after a rising edge; leaves start high for the next word
  task automatic send_word(input logic [1:0] op, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    start <= 1'b1;
    operation <= op;
    coord_x <= x;
    coord_y <= y;
    do @(posedge clk); while (busy !== 1'b0);
    apply_word(op, x, y);
    if (op != OP_UNUSED)
      items_sent++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 25);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] near_coord(input longint c, input longint span);
    longint v;
    v = c - span + longint'($urandom_range(0, 32'(2 * span)));
    return clamp_coord(v);
  endfunction

  task automatic test_empty_polygon();
    send_word(OP_QUERY, '0, '0);
  endtask

  task automatic test_ignored_code();
    send_word(OP_UNUSED, COORD_MIN, COORD_MAX);
  endtask

  task automatic test_extreme_vertices();
    send_word(OP_APPEND, COORD_MAX, COORD_MAX);
    send_word(OP_QUERY, COORD_MAX, COORD_MAX);
    send_word(OP_APPEND, COORD_MIN, COORD_MIN);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_APPEND, COORD_MAX, COORD_MIN);
    send_word(OP_QUERY, 32'sd1000, -32'sd1000);
    send_word(OP_QUERY, -32'sd1000, 32'sd1000);
  endtask

  task automatic test_vertex_overflow();
    int k;
    for (k = 3; k < VERTEX_DEPTH; k++)
      send_word(OP_APPEND, k * 1000, -k * 1500);
    send_word(OP_APPEND, COORD_MIN, COORD_MAX);
    send_word(OP_QUERY, 32'sd5000, -32'sd6000);
  endtask

  task automatic test_clear();
    send_word(OP_CLEAR, COORD_MAX, COORD_MIN);
    send_word(OP_QUERY, '0, '0);
  endtask

  // mostly well formed polygons with random shape and scale, some noise
  task automatic test_random_polygons();
    logic signed [COORD_W-1:0] vx[$], vy[$];
    longint cx, cy, span;
    int nv, nq, k, pick, idx;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 6) != 0) begin
        send_word(OP_CLEAR, $urandom(), $urandom());
        pace_sender();
        vx.delete();
        vy.delete();
      end
      pick = $urandom_range(0, 9);
      nv = (pick == 0) ? $urandom_range(0, 2) :
           (pick == 1) ? $urandom_range(VERTEX_DEPTH + 1, VERTEX_DEPTH + 4) :
           $urandom_range(3, VERTEX_DEPTH);
      cx = int'($urandom());
      cy = int'($urandom());
      span = longint'(1) << $urandom_range(1, 30);
      for (k = 0; k < nv; k++) begin
        vx.insert(vx.size(), near_coord(cx, span));
        vy.insert(vy.size(), near_coord(cy, span));
        send_word(OP_APPEND, vx[vx.size()-1], vy[vy.size()-1]);
        pace_sender();
      end
      nq = $urandom_range(2, 8);
      for (k = 0; k < nq; k++) begin
        pick = $urandom_range(0, 9);
        idx = (vx.size() > 0) ? $urandom_range(0, vx.size() - 1) : 0;
        if (pick == 9 || vx.size() == 0)
          send_word(OP_QUERY, $urandom(), $urandom());
        else if (pick == 8)
          send_word(OP_QUERY, vx[idx], vy[idx]);
        else if (pick >= 6)
          send_word(OP_QUERY, near_coord(cx, span), vy[idx]);
        else
          send_word(OP_QUERY, near_coord(cx, span), near_coord(cy, span));
        pace_sender();
      end
      if ($urandom_range(0, 7) == 0) begin
        send_word(OP_UNUSED, $urandom(), $urandom());
        pace_sender();
      end
      if ($urandom_range(0, 9) == 0) begin
        vx.insert(vx.size(), $urandom());
        vy.insert(vy.size(), $urandom());
        send_word(OP_APPEND, vx[vx.size()-1], vy[vy.size()-1]);
        pace_sender();
      end
    end
  endtask

  task automatic finish_run();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("point_in_polygon_test_top_test: clean");
    else
      $display("point_in_polygon_test_top_test: errors");
    $finish;
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst && valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result word with no query pending");
      end else begin
        want = pending_answers.pop_front();
        if (inside_res !== want.in_poly)
          report_mismatch($sformatf("inside_res %b, want %b", inside_res, want.in_poly));
        if (vertex_overflow !== want.overflow)
          report_mismatch($sformatf("vertex_overflow %b, want %b",
                                    vertex_overflow, want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || valid === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("point_in_polygon_test_top_test: errors");
      $finish;
    end
  end

  initial begin
    empty_polygon();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_polygon();
    test_ignored_code();
    test_extreme_vertices();
    test_vertex_overflow();
    test_clear();
    test_random_polygons();
    finish_run();
  end

endmodule
